[design/lpg_pkg.sv]
// ----------------------------------------------------------------------------
// lpg_pkg: shared definitions for the line pixel generator
// Coordinate widths, command codes, sequencer states and the divider status.
// ----------------------------------------------------------------------------
package lpg_pkg;

    localparam int COORD_BITS = 12;
    localparam int DELTA_W    = COORD_BITS + 1;
    localparam int PROD_W     = 2 * DELTA_W;
    localparam int COLOR_W    = 24;
    localparam int CNT_W      = $clog2(COORD_BITS);

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_START,
        ST_DIV,
        ST_EMIT
    } lpg_state_t;

    typedef struct packed {
        logic done;
    } div_status_t;

endpackage

[design/lpg_divider.sv]
// ----------------------------------------------------------------------------
// lpg_divider: radix-2 restoring divider
// Produces one quotient bit per cycle for an unsigned dividend and divisor.
// ----------------------------------------------------------------------------
module lpg_divider
    import lpg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [PROD_W-1:0]     dividend,
    input  logic [DELTA_W-1:0]    divisor,
    output logic [COORD_BITS-1:0] quotient,
    output div_status_t           status
);

    logic [PROD_W-1:0]     rem_reg;
    logic [PROD_W-1:0]     dsh_reg;
    logic [COORD_BITS-1:0] q_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic                  ge;
    logic [PROD_W-1:0]     diff;

    assign ge   = rem_reg >= dsh_reg;
    assign diff = rem_reg - dsh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(COORD_BITS - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend;
            dsh_reg <= PROD_W'(divisor) << (COORD_BITS - 1);
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_reg <= diff;
            end
            dsh_reg <= dsh_reg >> 1;
            q_reg   <= {q_reg[COORD_BITS-2:0], ge};
        end
    end

    assign quotient    = q_reg;
    assign status.done = done_reg;

endmodule

[design/line_pixel_generator.sv]
// ----------------------------------------------------------------------------
// line_pixel_generator: integer line rasterizer with exact division
// Walks a loaded line along its major axis and emits one pixel per step.
// ----------------------------------------------------------------------------
// A load transfer (cmd low) stores two endpoints and a color, and the input
// stays ready. A step transfer (cmd high) with a line loaded returns the
// next pixel through these steps in order: the multiply of the walk offset
// by the minor delta, the divider start, the divider iterations, one per
// bit of the twelve-bit quotient, its finish flag, and the add of the origin
// into the output register; the input stays not ready meanwhile, and that
// last step waits for as long as an earlier pixel sits unaccepted at the
// output. A step with no line loaded returns nothing, and the input stays
// ready. The final pixel of a line has last_pixel set.
module line_pixel_generator
    import lpg_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         cmd,
    input  logic signed [COORD_BITS-1:0] x_start,
    input  logic signed [COORD_BITS-1:0] y_start,
    input  logic signed [COORD_BITS-1:0] x_end,
    input  logic signed [COORD_BITS-1:0] y_end,
    input  logic [COLOR_W-1:0]           line_color,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [COORD_BITS-1:0] pixel_x,
    output logic signed [COORD_BITS-1:0] pixel_y,
    output logic [COLOR_W-1:0]           pixel_color,
    output logic                         last_pixel
);

    lpg_state_t state_reg;
    lpg_state_t state_next;

    logic signed [COORD_BITS-1:0] origin_x_reg;
    logic signed [COORD_BITS-1:0] origin_y_reg;
    logic signed [DELTA_W-1:0]    delta_x_reg;
    logic signed [DELTA_W-1:0]    delta_y_reg;
    logic                         steep_reg;
    logic signed [COORD_BITS-1:0] walk_reg;
    logic signed [COORD_BITS-1:0] walk_end_reg;
    logic [COLOR_W-1:0]           color_reg;
    logic                         active_reg;
    logic signed [PROD_W-1:0]     product_reg;
    logic                         neg_reg;

    logic                         out_valid_reg;
    logic signed [COORD_BITS-1:0] pixel_x_reg;
    logic signed [COORD_BITS-1:0] pixel_y_reg;
    logic [COLOR_W-1:0]           pixel_color_reg;
    logic                         last_pixel_reg;

    logic                         in_fire;
    logic                         load_fire;
    logic                         div_start;
    logic                         emit_fire;

    logic signed [DELTA_W-1:0]    dx_load;
    logic signed [DELTA_W-1:0]    dy_load;
    logic [DELTA_W-1:0]           mag_dx;
    logic [DELTA_W-1:0]           mag_dy;
    logic                         steep_load;
    logic signed [COORD_BITS-1:0] a_load;
    logic signed [COORD_BITS-1:0] b_load;
    logic                         a_lt_b;

    logic signed [COORD_BITS-1:0] origin_major;
    logic signed [COORD_BITS-1:0] origin_minor;
    logic signed [DELTA_W-1:0]    delta_major;
    logic signed [DELTA_W-1:0]    delta_minor;
    logic signed [DELTA_W-1:0]    offset;
    logic signed [PROD_W-1:0]     product;
    logic [PROD_W-1:0]            dividend;
    logic [DELTA_W-1:0]           divisor;
    logic [COORD_BITS-1:0]        quotient;
    div_status_t                  div_status;
    logic [COORD_BITS-1:0]        q_signed;
    logic signed [COORD_BITS-1:0] minor_coord;
    logic signed [COORD_BITS-1:0] walk_next;
    logic                         last;

    // Line setup on a load.
    assign dx_load    = {x_end[COORD_BITS-1], x_end} - {x_start[COORD_BITS-1], x_start};
    assign dy_load    = {y_end[COORD_BITS-1], y_end} - {y_start[COORD_BITS-1], y_start};
    assign mag_dx     = dx_load[DELTA_W-1] ? -dx_load : dx_load;
    assign mag_dy     = dy_load[DELTA_W-1] ? -dy_load : dy_load;
    assign steep_load = mag_dy > mag_dx;
    assign a_load     = steep_load ? y_start : x_start;
    assign b_load     = steep_load ? y_end : x_end;
    assign a_lt_b     = a_load < b_load;

    // Per-pixel arithmetic.
    assign origin_major = steep_reg ? origin_y_reg : origin_x_reg;
    assign origin_minor = steep_reg ? origin_x_reg : origin_y_reg;
    assign delta_major  = steep_reg ? delta_y_reg : delta_x_reg;
    assign delta_minor  = steep_reg ? delta_x_reg : delta_y_reg;
    assign offset       = {walk_reg[COORD_BITS-1], walk_reg}
                        - {origin_major[COORD_BITS-1], origin_major};
    assign product      = PROD_W'(offset) * PROD_W'(delta_minor);
    assign dividend     = product_reg[PROD_W-1] ? PROD_W'(-product_reg) : PROD_W'(product_reg);
    assign divisor      = delta_major[DELTA_W-1] ? DELTA_W'(-delta_major)
                                                 : DELTA_W'(delta_major);
    assign q_signed     = neg_reg ? -quotient : quotient;
    assign minor_coord  = origin_minor + $signed(q_signed);
    assign walk_next    = walk_reg + COORD_BITS'(1);
    assign last         = walk_next == walk_end_reg;

    lpg_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .quotient (quotient),
        .status   (div_status)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && (cmd == CMD_STEP) && active_reg)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:   state_next = ST_START;
            ST_START: state_next = ST_DIV;
            ST_DIV:
            begin
                if (div_status.done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        div_start = 1'b0;
        emit_fire = 1'b0;
        unique case (state_reg)
            ST_IDLE:  in_ready  = 1'b1;
            ST_MUL:   ;
            ST_START: div_start = 1'b1;
            ST_DIV:   ;
            ST_EMIT:  emit_fire = !out_valid_reg || out_ready;
            default:  ;
        endcase
    end

    assign in_fire   = in_valid && in_ready;
    assign load_fire = in_fire && (cmd == CMD_LOAD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_fire)
            begin
                active_reg <= a_load != b_load;
            end
            else if (emit_fire)
            begin
                active_reg <= !last;
            end
            if (emit_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_fire)
        begin
            origin_x_reg <= x_start;
            origin_y_reg <= y_start;
            delta_x_reg  <= dx_load;
            delta_y_reg  <= dy_load;
            steep_reg    <= steep_load;
            walk_reg     <= a_lt_b ? a_load : b_load;
            walk_end_reg <= a_lt_b ? b_load : a_load;
            color_reg    <= line_color;
        end
        else if (emit_fire)
        begin
            walk_reg <= walk_next;
        end
        if (state_reg == ST_MUL)
        begin
            product_reg <= product;
        end
        if (div_start)
        begin
            neg_reg <= product_reg[PROD_W-1] ^ delta_major[DELTA_W-1];
        end
        if (emit_fire)
        begin
            pixel_x_reg     <= steep_reg ? minor_coord : walk_reg;
            pixel_y_reg     <= steep_reg ? walk_reg : minor_coord;
            pixel_color_reg <= color_reg;
            last_pixel_reg  <= last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_x     = pixel_x_reg;
    assign pixel_y     = pixel_y_reg;
    assign pixel_color = pixel_color_reg;
    assign last_pixel  = last_pixel_reg;

endmodule

[design/lpg_checker.sv]
// ----------------------------------------------------------------------------
// lpg_checker: port-level checks for the line pixel generator
// Watches the handshakes and sequencing seen at the top-level ports.
// ----------------------------------------------------------------------------
module lpg_checker
    import lpg_pkg::*;
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         cmd,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic signed [COORD_BITS-1:0] pixel_x,
    input logic signed [COORD_BITS-1:0] pixel_y,
    input logic [COLOR_W-1:0]           pixel_color,
    input logic                         last_pixel
);

    // A stalled result keeps its valid and its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_x) && $stable(pixel_y)
            && $stable(pixel_color) && $stable(last_pixel))
    else $error("stalled result changed");

    // A load leaves the input ready in the cycle after it.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (cmd == CMD_LOAD) |=> in_ready)
    else $error("input not ready after a load");

    // A new result only appears after the block has been busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without a step being computed");

    // When a result appears, the input was not ready in the previous cycle or in the one before it.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_ready, 2) == 1'b0 || !$past(in_ready))
    else $error("input accepted while a pixel was being emitted");

endmodule

bind line_pixel_generator lpg_checker u_lpg_checker (.*);
